/* rtl/mm4_pkg.sv */
// Shared types, constants and saturation helper for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int IDX_W     = $clog2(DIM);
  localparam int CMD_W     = 2;
  localparam int COLF_W    = 2;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = PROD_W + $clog2(DIM);
  localparam int PAY_W     = COLF_W + DIM * ELEM_W;
  localparam int TDATA_W   = ((PAY_W + 7) / 8) * 8;

  localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef logic [DIM-1:0][ELEM_W-1:0] col_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
  } issue_t;

  function automatic logic [ELEM_W-1:0] saturate(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0]  sh;
    logic [ACC_W-ELEM_W:0]    top;
    sh  = acc >>> FRAC_BITS;
    top = sh[ACC_W-1:ELEM_W-1];
    if ((&top) || !(|top)) begin
      return sh[ELEM_W-1:0];
    end else if (sh[ACC_W-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

/* rtl/mm4_col_mem.sv */
// Column-wide matrix store with one write port and one registered read port.
module mm4_col_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [mm4_pkg::IDX_W-1:0] waddr_i,
  input  mm4_pkg::col_t             wdata_i,
  input  logic                      re_i,
  input  logic [mm4_pkg::IDX_W-1:0] raddr_i,
  output mm4_pkg::col_t             rdata_o
);
  import mm4_pkg::*;

  col_t mem [DIM];
  col_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mm4_seq.sv */
// Read sequencer that walks product columns and inner-product terms for a compute run.
module mm4_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            adv_i,
  output logic            busy_o,
  output mm4_pkg::issue_t issue_o
);
  import mm4_pkg::*;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] c_q, c_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic             final_term;

  assign final_term = (c_q == IDX_W'(DIM - 1)) && (k_q == IDX_W'(DIM - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv_i && final_term) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    c_d = c_q;
    k_d = k_q;
    unique case (state_q)
      ST_IDLE: begin
        c_d = '0;
        k_d = '0;
      end
      ST_RUN: begin
        if (adv_i) begin
          if (k_q == IDX_W'(DIM - 1)) begin
            k_d = '0;
            c_d = c_q + IDX_W'(1);
          end else begin
            k_d = k_q + IDX_W'(1);
          end
        end
      end
      default: begin
        c_d = '0;
        k_d = '0;
      end
    endcase
  end

  always_comb begin
    busy_o        = 1'b0;
    issue_o.valid = 1'b0;
    unique case (state_q)
      ST_IDLE: busy_o = 1'b0;
      ST_RUN: begin
        busy_o        = 1'b1;
        issue_o.valid = 1'b1;
      end
      default: busy_o = 1'b0;
    endcase
    issue_o.col = c_q;
    issue_o.k   = k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

endmodule

/* rtl/mm4_mac.sv */
// Four-lane multiply, accumulate and saturate datapath for one product column at a time.
module mm4_mac (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  mm4_pkg::issue_t           issue_i,
  input  mm4_pkg::col_t             a_col_i,
  input  mm4_pkg::col_t             b_col_i,
  output logic                      res_valid_o,
  output logic [mm4_pkg::IDX_W-1:0] res_col_o,
  output mm4_pkg::col_t             res_data_o
);
  import mm4_pkg::*;

  issue_t                  tag1_q, tag2_q;
  logic signed [PROD_W-1:0] prod_q [DIM];
  logic signed [ACC_W-1:0]  acc_q  [DIM];
  logic                     done_q;
  logic [IDX_W-1:0]         dcol_q;
  logic [ELEM_W-1:0]        b_sel;

  assign b_sel = b_col_i[tag1_q.k];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      done_q <= 1'b0;
      dcol_q <= '0;
    end else if (adv_i) begin
      tag1_q <= issue_i;
      tag2_q <= tag1_q;
      done_q <= tag2_q.valid && (tag2_q.k == IDX_W'(DIM - 1));
      dcol_q <= tag2_q.col;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int r = 0; r < DIM; r++) begin
        prod_q[r] <= $signed(a_col_i[r]) * $signed(b_sel);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && tag2_q.valid) begin
      for (int r = 0; r < DIM; r++) begin
        acc_q[r] <= ((tag2_q.k == '0) ? ACC_W'(0) : acc_q[r])
                  + {{(ACC_W-PROD_W){prod_q[r][PROD_W-1]}}, prod_q[r]};
      end
    end
  end

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      res_data_o[r] = saturate(acc_q[r]);
    end
  end

  assign res_valid_o = done_q;
  assign res_col_o   = dcol_q;

endmodule

/* rtl/matrix4x4_multiply.sv */
// Top level of the 4x4 signed Q16.16 matrix multiplier with stream input and output.
//
// A load beat writes one column of A or B. A compute beat reads one column of A
// and the current column of B per cycle from the two column-wide memories while
// the pipeline does not stall, and no input beat is accepted until the last
// term of the product has been read. Each product column passes through the
// memory read registers, the product and accumulator registers and the output
// register. An unused command is accepted and ignored. The pipeline stalls while
// a finished column cannot move into the output register. Entries hold no
// defined value until loaded, and a product that uses such an entry is
// undefined.
module matrix4x4_multiply (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // Fields from bit 0: column, elem0, elem1, elem2, elem3, zero fill.
  input  logic [mm4_pkg::TDATA_W-1:0]  s_axis_tdata_i,
  // Fields from bit 0: command.
  input  logic [mm4_pkg::CMD_W-1:0]    s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // Fields from bit 0: out_column, prod0, prod1, prod2, prod3, zero fill.
  output logic [mm4_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);
  import mm4_pkg::*;

  logic             in_fire;
  logic             busy;
  logic             adv;
  logic             we_a, we_b, start;
  logic [IDX_W-1:0] waddr;
  col_t             wdata;
  col_t             a_col, b_col;
  issue_t           issue;
  logic             res_valid;
  logic [IDX_W-1:0] res_col;
  col_t             res_data;
  cmd_e             cmd;

  logic             out_valid_q;
  logic [COLF_W-1:0] out_col_q;
  col_t             out_data_q;
  logic             out_last_q;

  assign s_axis_tready_o = !busy;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd             = cmd_e'(s_axis_tuser_i);
  assign waddr           = s_axis_tdata_i[IDX_W-1:0];
  assign wdata           = s_axis_tdata_i[PAY_W-1:COLF_W];

  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    start = 1'b0;
    if (in_fire) begin
      unique case (cmd)
        CMD_LOAD_A:  we_a  = 1'b1;
        CMD_LOAD_B:  we_b  = 1'b1;
        CMD_COMPUTE: start = 1'b1;
        default:     start = 1'b0;
      endcase
    end
  end

  assign adv = !(res_valid && out_valid_q && !m_axis_tready_i);

  mm4_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .adv_i   (adv),
    .busy_o  (busy),
    .issue_o (issue)
  );

  mm4_col_mem u_mem_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (adv),
    .raddr_i (issue.k),
    .rdata_o (a_col)
  );

  mm4_col_mem u_mem_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (adv),
    .raddr_i (issue.col),
    .rdata_o (b_col)
  );

  mm4_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .issue_i     (issue),
    .a_col_i     (a_col),
    .b_col_i     (b_col),
    .res_valid_o (res_valid),
    .res_col_o   (res_col),
    .res_data_o  (res_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && adv) begin
      out_col_q  <= COLF_W'(res_col);
      out_data_q <= res_data;
      out_last_q <= (res_col == IDX_W'(DIM - 1));
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TDATA_W'({out_data_q, out_col_q});
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the 4x4 signed Q16.16 matrix multiplier.
`timescale 1ns / 1ps

module tb;
  import mm4_pkg::*;

  localparam int SUM_W = 2 * ELEM_W + 2;
  localparam int RANDOM_ITEMS = 200;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [ELEM_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [ELEM_W-1:0] Q_ONE = 32'h0001_0000;

  typedef struct {
    logic [COLF_W-1:0] idx;
    col_t              rows;
    logic              last;
  } product_col_t;

  class product_checker;
    logic signed [ELEM_W-1:0] left_cols [DIM][DIM];
    logic signed [ELEM_W-1:0] right_cols [DIM][DIM];
    product_col_t pending [$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) begin
        $display("mismatch: %s", msg);
      end
    endfunction

    function logic [ELEM_W-1:0] dot_entry(int r, int c);
      localparam logic signed [SUM_W-1:0] SUM_HI =
        {{(SUM_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
      localparam logic signed [SUM_W-1:0] SUM_LO =
        {{(SUM_W-ELEM_W+1){1'b1}}, {(ELEM_W-1){1'b0}}};
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] sh;
      sum = '0;
      for (int k = 0; k < DIM; k++) begin
        sum = sum + left_cols[k][r] * right_cols[c][k];
      end
      sh = sum >>> FRAC_BITS;
      if (sh > SUM_HI) return Q_MAX;
      if (sh < SUM_LO) return Q_MIN;
      return sh[ELEM_W-1:0];
    endfunction

    function void note_input(logic [CMD_W-1:0] cmd, logic [COLF_W-1:0] col, col_t elems);
      product_col_t entry;
      case (cmd)
        CMD_LOAD_A: begin
          for (int r = 0; r < DIM; r++) left_cols[col][r] = elems[r];
        end
        CMD_LOAD_B: begin
          for (int r = 0; r < DIM; r++) right_cols[col][r] = elems[r];
        end
        CMD_COMPUTE: begin
          for (int c = 0; c < DIM; c++) begin
            entry.idx = c[COLF_W-1:0];
            for (int r = 0; r < DIM; r++) entry.rows[r] = dot_entry(r, c);
            entry.last = (c == DIM - 1);
            pending.push_back(entry);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [TDATA_W-1:0] beat, logic tlast);
      product_col_t got;
      product_col_t want;
      got.idx  = beat[COLF_W-1:0];
      got.rows = beat[COLF_W +: DIM*ELEM_W];
      got.last = tlast;
      if (pending.size() == 0) begin
        note_error($sformatf("unexpected product column %0d", got.idx));
        return;
      end
      want = pending.pop_front();
      if (got.idx !== want.idx) begin
        note_error($sformatf("column index expected %0d got %0d", want.idx, got.idx));
      end
      for (int r = 0; r < DIM; r++) begin
        if (got.rows[r] !== want.rows[r]) begin
          note_error($sformatf("column %0d row %0d expected %h got %h",
                               want.idx, r, want.rows[r], got.rows[r]));
        end
      end
      if (got.last !== want.last) begin
        note_error($sformatf("column %0d tlast expected %0b got %0b",
                             want.idx, want.last, got.last));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0] s_tuser = '0;
  logic m_tready = 1'b0;
  logic s_axis_tready_o;
  logic m_axis_tvalid_o;
  logic [TDATA_W-1:0] m_axis_tdata_o;
  logic m_axis_tlast_o;

  int send_idle_pct = 32;
  int recv_idle_pct = 74;
  product_checker sb = new();

  always #4 clk_i = ~clk_i;

  matrix4x4_multiply dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [COLF_W-1:0] col, col_t elems);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(TDATA_W-PAY_W){1'b0}}, elems, col};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_input(cmd, col, elems);
  endtask

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return '1;
      4, 5, 6: return $urandom;
      default: return 32'($urandom_range(0, 524288)) - 32'd262144;
    endcase
  endfunction

  function automatic col_t rand_col();
    col_t elems;
    for (int r = 0; r < DIM; r++) elems[r] = rand_elem();
    return elems;
  endfunction

  function automatic col_t unit_col(int k);
    col_t elems;
    elems = '0;
    elems[k] = Q_ONE;
    return elems;
  endfunction

  task automatic load_matrix(logic [CMD_W-1:0] cmd, logic [ELEM_W-1:0] value);
    for (int c = 0; c < DIM; c++) send_beat(cmd, c[COLF_W-1:0], {DIM{value}});
  endtask

  initial begin
    int counted;
    int pick;
    logic [CMD_W-1:0] cmd;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-scale operands saturate high and low; all-minimum sums exceed 64 bits.
    load_matrix(CMD_LOAD_A, Q_MAX);
    load_matrix(CMD_LOAD_B, Q_MAX);
    send_beat(CMD_COMPUTE, '0, '0);
    load_matrix(CMD_LOAD_B, Q_MIN);
    send_beat(CMD_COMPUTE, '1, '1);
    load_matrix(CMD_LOAD_A, Q_MIN);
    send_beat(CMD_COMPUTE, '0, '0);
    send_beat(CMD_UNUSED, 2'd2, rand_col());
    for (int c = 0; c < DIM; c++) send_beat(CMD_LOAD_A, c[COLF_W-1:0], unit_col(c));
    send_beat(CMD_COMPUTE, '0, rand_col());

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      case (counted * 3 / RANDOM_ITEMS)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      pick = $urandom_range(99);
      if (pick < 5) cmd = CMD_UNUSED;
      else if (pick < 45) cmd = CMD_LOAD_A;
      else if (pick < 85) cmd = CMD_LOAD_B;
      else cmd = CMD_COMPUTE;
      send_beat(cmd, 2'($urandom_range(3)), rand_col());
      if (cmd != CMD_UNUSED) counted++;
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
